[rtl/core/ttdd_pkg.sv]
// Shared types, register map and field widths for the tilt to differential drive block.
// No dependencies; every other file of the block but ttdd_div_pipe refers to it by scoped names.
package ttdd_pkg;

  localparam int THR_W      = 16;
  localparam int DUTY_W     = 12;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_FWD_DEAD   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FWD_SAT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TURN_DEAD  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TURN_SAT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE = 3'd4;

  localparam logic [THR_W-1:0]  RST_FWD_DEAD   = 16'd3000;
  localparam logic [THR_W-1:0]  RST_FWD_SAT    = 16'd6000;
  localparam logic [THR_W-1:0]  RST_TURN_DEAD  = 16'd4000;
  localparam logic [THR_W-1:0]  RST_TURN_SAT   = 16'd6000;
  localparam logic [DUTY_W-1:0] RST_FULL_SCALE = 12'd1000;

  typedef struct packed {
    logic [THR_W-1:0]  fwd_dead;
    logic [THR_W-1:0]  fwd_sat;
    logic [THR_W-1:0]  turn_dead;
    logic [THR_W-1:0]  turn_sat;
    logic [DUTY_W-1:0] full_scale;
  } cfg_regs_t;

  typedef struct packed {
    logic              pos;
    logic [DUTY_W-1:0] mag;
  } crv_t;

  typedef struct packed {
    logic pos;
    logic zero;
    logic full;
  } crv_sb_t;

  typedef struct packed {
    logic              fwd;
    logic              scale_left;
    logic              scale_right;
    logic [DUTY_W-1:0] base;
  } mix_sb_t;

  function automatic int div_width(int fsc);
    return THR_W + $clog2(fsc + 1);
  endfunction

endpackage

[rtl/core/ttdd_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per register stage, with a sideband.
// Caller keeps the numerator below the denominator shifted by Q_W bits; no other dependencies.
module ttdd_div_pipe #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 12,
  parameter int Q_W   = 12,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic             vld_o,
  output logic [Q_W-1:0]   quo_o,
  output logic [SB_W-1:0]  sb_o
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             vld_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];
  logic [SB_W-1:0]  sb_r  [Q_W];
  logic [CW-1:0]    rem_r [Q_W-1];
  logic [DEN_W-1:0] den_r [Q_W-1];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int BIT = Q_W - 1 - s;
    logic             vld_in;
    logic [CW-1:0]    rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic [SB_W-1:0]  sb_in;
    logic [CW-1:0]    trial;
    logic             ge;
    logic [Q_W-1:0]   quo_nxt;

    if (s == 0) begin : g_head
      assign vld_in = vld_i;
      assign rem_in = CW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
      assign sb_in  = sb_i;
    end else begin : g_body
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
      assign sb_in  = sb_r[s-1];
    end

    assign trial = CW'(den_in) << BIT;
    assign ge    = rem_in >= trial;

    always_comb begin
      quo_nxt      = quo_in;
      quo_nxt[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      quo_r[s] <= quo_nxt;
      sb_r[s]  <= sb_in;
    end

    if (s < Q_W - 1) begin : g_keep
      logic [CW-1:0] rem_nxt;

      assign rem_nxt = ge ? rem_in - trial : rem_in;

      always_ff @(posedge clk) begin
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_in;
      end
    end
  end

  assign vld_o = vld_r[Q_W-1];
  assign quo_o = quo_r[Q_W-1];
  assign sb_o  = sb_r[Q_W-1];

endmodule

[rtl/core/ttdd_cfg.sv]
// APB register file and sequential divider that derives the two curve divisors.
// Depends on ttdd_pkg for the register map, reset values and the config struct.
module ttdd_cfg #(
  parameter int FRACTION_SCALE = 1000
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [ttdd_pkg::CFG_ADDR_W-1:0]             paddr,
  input  logic [ttdd_pkg::CFG_DATA_W-1:0]             pwdata,
  output logic [ttdd_pkg::CFG_DATA_W-1:0]             prdata,
  output ttdd_pkg::cfg_regs_t                         regs_o,
  output logic [ttdd_pkg::div_width(FRACTION_SCALE)-1:0] fwd_div_o,
  output logic [ttdd_pkg::div_width(FRACTION_SCALE)-1:0] turn_div_o,
  output logic                                        busy_o
);

  localparam int DIV_W  = ttdd_pkg::div_width(FRACTION_SCALE);
  localparam int CNT_W  = $clog2(DIV_W);
  localparam int THR_W  = ttdd_pkg::THR_W;
  localparam int DUTY_W = ttdd_pkg::DUTY_W;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_LOAD_FWD  = 3'd1;
  localparam logic [2:0] ST_RUN_FWD   = 3'd2;
  localparam logic [2:0] ST_LOAD_TURN = 3'd3;
  localparam logic [2:0] ST_RUN_TURN  = 3'd4;

  logic [THR_W-1:0]  fwd_dead_r;
  logic [THR_W-1:0]  fwd_sat_r;
  logic [THR_W-1:0]  turn_dead_r;
  logic [THR_W-1:0]  turn_sat_r;
  logic [DUTY_W-1:0] full_scale_r;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [DIV_W-1:0]  shreg_r;
  logic [DUTY_W-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]  fwd_div_r;
  logic [DIV_W-1:0]  turn_div_r;

  logic                           wr_en;
  logic [ttdd_pkg::REG_IDX_W-1:0] reg_idx;
  logic [DUTY_W:0]                rem_sh;
  logic [DUTY_W:0]                rem_sub;
  logic                           ge;
  logic [DIV_W-1:0]               step_shreg;
  logic [DUTY_W-1:0]              step_rem;
  logic [THR_W-1:0]               span;
  logic [DIV_W-1:0]               dividend;
  logic [DIV_W-1:0]               quo_fin;
  logic                           last;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ttdd_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_dead_r   <= ttdd_pkg::RST_FWD_DEAD;
      fwd_sat_r    <= ttdd_pkg::RST_FWD_SAT;
      turn_dead_r  <= ttdd_pkg::RST_TURN_DEAD;
      turn_sat_r   <= ttdd_pkg::RST_TURN_SAT;
      full_scale_r <= ttdd_pkg::RST_FULL_SCALE;
    end else if (wr_en) begin
      unique case (reg_idx)
        ttdd_pkg::REG_FWD_DEAD:   fwd_dead_r   <= pwdata[THR_W-1:0];
        ttdd_pkg::REG_FWD_SAT:    fwd_sat_r    <= pwdata[THR_W-1:0];
        ttdd_pkg::REG_TURN_DEAD:  turn_dead_r  <= pwdata[THR_W-1:0];
        ttdd_pkg::REG_TURN_SAT:   turn_sat_r   <= pwdata[THR_W-1:0];
        ttdd_pkg::REG_FULL_SCALE: full_scale_r <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ttdd_pkg::REG_FWD_DEAD:   prdata = ttdd_pkg::CFG_DATA_W'(fwd_dead_r);
      ttdd_pkg::REG_FWD_SAT:    prdata = ttdd_pkg::CFG_DATA_W'(fwd_sat_r);
      ttdd_pkg::REG_TURN_DEAD:  prdata = ttdd_pkg::CFG_DATA_W'(turn_dead_r);
      ttdd_pkg::REG_TURN_SAT:   prdata = ttdd_pkg::CFG_DATA_W'(turn_sat_r);
      ttdd_pkg::REG_FULL_SCALE: prdata = ttdd_pkg::CFG_DATA_W'(full_scale_r);
      default:                  prdata = '0;
    endcase
  end

  assign rem_sh     = {rem_r, shreg_r[DIV_W-1]};
  assign ge         = rem_sh >= {1'b0, full_scale_r};
  assign rem_sub    = rem_sh - {1'b0, full_scale_r};
  assign step_shreg = {shreg_r[DIV_W-2:0], ge};
  assign step_rem   = ge ? rem_sub[DUTY_W-1:0] : rem_sh[DUTY_W-1:0];
  assign span       = (state_r == ST_LOAD_TURN) ? turn_sat_r - turn_dead_r
                                                : fwd_sat_r - fwd_dead_r;
  assign dividend   = DIV_W'(span) * DIV_W'(FRACTION_SCALE);
  assign quo_fin    = (full_scale_r == '0) ? '0 : step_shreg;
  assign last       = cnt_r == '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      state_nxt = ST_IDLE;
      ST_LOAD_FWD:  state_nxt = ST_RUN_FWD;
      ST_RUN_FWD:   state_nxt = last ? ST_LOAD_TURN : ST_RUN_FWD;
      ST_LOAD_TURN: state_nxt = ST_RUN_TURN;
      ST_RUN_TURN:  state_nxt = last ? ST_IDLE : ST_RUN_TURN;
      default:      state_nxt = ST_IDLE;
    endcase
    if (wr_en) begin
      state_nxt = ST_LOAD_FWD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD_FWD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD_FWD || state_r == ST_LOAD_TURN) begin
      shreg_r <= dividend;
      rem_r   <= '0;
      cnt_r   <= CNT_W'(DIV_W - 1);
    end else if (state_r == ST_RUN_FWD || state_r == ST_RUN_TURN) begin
      shreg_r <= step_shreg;
      rem_r   <= step_rem;
      cnt_r   <= cnt_r - CNT_W'(1);
    end
    if (state_r == ST_RUN_FWD && last) begin
      fwd_div_r <= quo_fin;
    end
    if (state_r == ST_RUN_TURN && last) begin
      turn_div_r <= quo_fin;
    end
  end

  assign regs_o.fwd_dead   = fwd_dead_r;
  assign regs_o.fwd_sat    = fwd_sat_r;
  assign regs_o.turn_dead  = turn_dead_r;
  assign regs_o.turn_sat   = turn_sat_r;
  assign regs_o.full_scale = full_scale_r;
  assign fwd_div_o         = fwd_div_r;
  assign turn_div_o        = turn_div_r;
  assign busy_o            = (state_r != ST_IDLE) || wr_en;

endmodule

[rtl/core/ttdd_curve.sv]
// One axis response curve: dead zone, saturation and clamped linear region, 16 stages.
// Depends on ttdd_pkg and ttdd_div_pipe.
module ttdd_curve #(
  parameter int SAMPLE_BITS    = 16,
  parameter int FRACTION_SCALE = 1000
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           vld_i,
  input  logic signed [SAMPLE_BITS-1:0]                  smp_i,
  input  logic [ttdd_pkg::THR_W-1:0]                     dead_i,
  input  logic [ttdd_pkg::THR_W-1:0]                     sat_i,
  input  logic [ttdd_pkg::DUTY_W-1:0]                    fs_i,
  input  logic [ttdd_pkg::div_width(FRACTION_SCALE)-1:0] div_i,
  output logic                                           vld_o,
  output ttdd_pkg::crv_t                                 crv_o
);

  localparam int SB     = SAMPLE_BITS;
  localparam int DUTY_W = ttdd_pkg::DUTY_W;
  localparam int FSC_W  = $clog2(FRACTION_SCALE + 1);
  localparam int DIV_W  = ttdd_pkg::div_width(FRACTION_SCALE);
  localparam int CMP_W  = (SB > ttdd_pkg::THR_W) ? SB : ttdd_pkg::THR_W;
  localparam int NUM_W  = SB + FSC_W;
  localparam int OVF_W  = (NUM_W > DIV_W + DUTY_W) ? NUM_W : DIV_W + DUTY_W;

  logic              neg_a;
  logic [SB-1:0]     mag_a;
  logic [CMP_W-1:0]  diff_a;

  logic              a_vld_r;
  logic              a_pos_r;
  logic              a_zero_r;
  logic              a_full_r;
  logic [SB-1:0]     a_diff_r;

  logic              b_vld_r;
  logic              b_pos_r;
  logic              b_zero_r;
  logic              b_full_r;
  logic [NUM_W-1:0]  b_num_r;

  logic              c_vld_r;
  logic [NUM_W-1:0]  c_num_r;
  ttdd_pkg::crv_sb_t c_sb_r;

  logic              d_vld;
  logic [DUTY_W-1:0] d_quo;
  ttdd_pkg::crv_sb_t d_sb;

  logic              o_vld_r;
  ttdd_pkg::crv_t    o_crv_r;
  ttdd_pkg::crv_t    o_crv_nxt;

  assign neg_a  = smp_i[SB-1];
  assign mag_a  = neg_a ? (~$unsigned(smp_i) + SB'(1)) : $unsigned(smp_i);
  assign diff_a = CMP_W'(mag_a) - CMP_W'(dead_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      a_vld_r <= vld_i;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      o_vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_pos_r  <= !neg_a && (smp_i != '0);
    a_zero_r <= CMP_W'(mag_a) < CMP_W'(dead_i);
    a_full_r <= CMP_W'(mag_a) > CMP_W'(sat_i);
    a_diff_r <= diff_a[SB-1:0];

    b_pos_r  <= a_pos_r;
    b_zero_r <= a_zero_r;
    b_full_r <= a_full_r || (div_i == '0);
    b_num_r  <= NUM_W'(a_diff_r) * NUM_W'(FRACTION_SCALE);

    c_num_r     <= b_num_r;
    c_sb_r.pos  <= b_pos_r;
    c_sb_r.zero <= b_zero_r;
    c_sb_r.full <= b_full_r || (OVF_W'(b_num_r) >= (OVF_W'(div_i) << DUTY_W));

    o_crv_r <= o_crv_nxt;
  end

  ttdd_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (DIV_W),
    .Q_W   (DUTY_W),
    .SB_W  ($bits(ttdd_pkg::crv_sb_t))
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (c_vld_r),
    .num_i (c_num_r),
    .den_i (div_i),
    .sb_i  (c_sb_r),
    .vld_o (d_vld),
    .quo_o (d_quo),
    .sb_o  (d_sb)
  );

  always_comb begin
    o_crv_nxt.pos = d_sb.pos;
    priority if (d_sb.zero) begin
      o_crv_nxt.mag = '0;
    end else if (d_sb.full || d_quo > fs_i) begin
      o_crv_nxt.mag = fs_i;
    end else begin
      o_crv_nxt.mag = d_quo;
    end
  end

  assign vld_o = o_vld_r;
  assign crv_o = o_crv_r;

endmodule

[rtl/core/ttdd_mix.sv]
// Differential mixing: scales one side by the turn amount and inverts duties when backward.
// Depends on ttdd_pkg and ttdd_div_pipe; 14 register stages.
module ttdd_mix (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  input  ttdd_pkg::crv_t              fwd_i,
  input  ttdd_pkg::crv_t              turn_i,
  input  logic [ttdd_pkg::DUTY_W-1:0] fs_i,
  output logic                        vld_o,
  output logic                        fwd_o,
  output logic [ttdd_pkg::DUTY_W-1:0] left_o,
  output logic [ttdd_pkg::DUTY_W-1:0] right_o
);

  localparam int DUTY_W = ttdd_pkg::DUTY_W;
  localparam int PROD_W = 2 * DUTY_W;

  logic              t_nz;
  logic              fs_nz;
  ttdd_pkg::mix_sb_t p_sb_nxt;

  logic              p_vld_r;
  logic [PROD_W-1:0] p_prod_r;
  ttdd_pkg::mix_sb_t p_sb_r;

  logic              d_vld;
  logic [DUTY_W-1:0] d_quo;
  ttdd_pkg::mix_sb_t d_sb;
  logic [DUTY_W-1:0] left_sel;
  logic [DUTY_W-1:0] right_sel;

  logic              o_vld_r;
  logic              o_fwd_r;
  logic [DUTY_W-1:0] o_left_r;
  logic [DUTY_W-1:0] o_right_r;

  assign t_nz  = turn_i.mag != '0;
  assign fs_nz = fs_i != '0;

  always_comb begin
    p_sb_nxt.fwd         = fwd_i.pos && (fwd_i.mag != '0);
    p_sb_nxt.scale_left  = !turn_i.pos && t_nz && fs_nz;
    p_sb_nxt.scale_right = turn_i.pos && t_nz && fs_nz;
    p_sb_nxt.base        = fwd_i.mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      p_vld_r <= vld_i;
      o_vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    p_prod_r  <= PROD_W'(fwd_i.mag) * PROD_W'(fs_i - turn_i.mag);
    p_sb_r    <= p_sb_nxt;
    o_fwd_r   <= d_sb.fwd;
    o_left_r  <= d_sb.fwd ? left_sel : fs_i - left_sel;
    o_right_r <= d_sb.fwd ? right_sel : fs_i - right_sel;
  end

  ttdd_div_pipe #(
    .NUM_W (PROD_W),
    .DEN_W (DUTY_W),
    .Q_W   (DUTY_W),
    .SB_W  ($bits(ttdd_pkg::mix_sb_t))
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (p_vld_r),
    .num_i (p_prod_r),
    .den_i (fs_i),
    .sb_i  (p_sb_r),
    .vld_o (d_vld),
    .quo_o (d_quo),
    .sb_o  (d_sb)
  );

  assign left_sel  = d_sb.scale_left ? d_quo : d_sb.base;
  assign right_sel = d_sb.scale_right ? d_quo : d_sb.base;

  assign vld_o   = o_vld_r;
  assign fwd_o   = o_fwd_r;
  assign left_o  = o_left_r;
  assign right_o = o_right_r;

endmodule

[rtl/core/tilt_to_differential_drive.sv]
// Top level: tilt pair to drive direction and left/right PWM duties.
// Depends on ttdd_pkg, ttdd_cfg, ttdd_curve, ttdd_mix (and ttdd_div_pipe below them).
//
//   channel   handshake                        payload
//   input     start / busy                     in_tilt_x, in_tilt_y
//   result    out_valid (one-cycle strobe)     out_drive_forward, out_left_duty, out_right_duty
//   config    psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// One transaction per cycle while busy is low; the result path runs through the
// two 12-stage restoring dividers (curve region, then turn scaling) plus 7 other stages.
// After reset and after every register write, busy stays high while a bit-serial divider
// derives the curve divisors. The receiver cannot stall, so the pipeline advances every cycle.
module tilt_to_differential_drive #(
  parameter int SAMPLE_BITS    = 16,
  parameter int FRACTION_SCALE = 1000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [SAMPLE_BITS-1:0]      in_tilt_x,
  input  logic signed [SAMPLE_BITS-1:0]      in_tilt_y,
  output logic                               out_valid,
  output logic                               out_drive_forward,
  output logic [ttdd_pkg::DUTY_W-1:0]        out_left_duty,
  output logic [ttdd_pkg::DUTY_W-1:0]        out_right_duty,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ttdd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ttdd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ttdd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int DIV_W = ttdd_pkg::div_width(FRACTION_SCALE);

  logic                          in_vld_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;

  ttdd_pkg::cfg_regs_t regs;
  logic [DIV_W-1:0]    fwd_div;
  logic [DIV_W-1:0]    turn_div;

  logic                fwd_vld;
  logic                turn_vld;
  ttdd_pkg::crv_t      fwd_crv;
  ttdd_pkg::crv_t      turn_crv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= in_tilt_x;
    y_r <= in_tilt_y;
  end

  ttdd_cfg #(
    .FRACTION_SCALE (FRACTION_SCALE)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .regs_o     (regs),
    .fwd_div_o  (fwd_div),
    .turn_div_o (turn_div),
    .busy_o     (busy)
  );

  ttdd_curve #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .FRACTION_SCALE (FRACTION_SCALE)
  ) u_fwd_curve (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (in_vld_r),
    .smp_i  (y_r),
    .dead_i (regs.fwd_dead),
    .sat_i  (regs.fwd_sat),
    .fs_i   (regs.full_scale),
    .div_i  (fwd_div),
    .vld_o  (fwd_vld),
    .crv_o  (fwd_crv)
  );

  ttdd_curve #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .FRACTION_SCALE (FRACTION_SCALE)
  ) u_turn_curve (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (in_vld_r),
    .smp_i  (x_r),
    .dead_i (regs.turn_dead),
    .sat_i  (regs.turn_sat),
    .fs_i   (regs.full_scale),
    .div_i  (turn_div),
    .vld_o  (turn_vld),
    .crv_o  (turn_crv)
  );

  ttdd_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (fwd_vld && turn_vld),
    .fwd_i   (fwd_crv),
    .turn_i  (turn_crv),
    .fs_i    (regs.full_scale),
    .vld_o   (out_valid),
    .fwd_o   (out_drive_forward),
    .left_o  (out_left_duty),
    .right_o (out_right_duty)
  );

  assign pready = 1'b1;

`ifndef SYNTHESIS
  localparam int LATENCY = 2 * ttdd_pkg::DUTY_W + 7;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted transaction produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted transaction");

  a_write_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite) |=> busy ##1 busy)
    else $error("busy dropped during divisor recompute");
`endif

endmodule

[tb/sv/tb_tilt_to_differential_drive.sv]
// Testbench for tilt_to_differential_drive: directed and random tilt pairs under many
// register settings, checked against an in-bench prediction of the curves and the mixing.
// Depends on ttdd_pkg and the RTL of the block; needs no files or arguments.
module tb_tilt_to_differential_drive;

  localparam int SAMPLE_W = 16;
  localparam longint unsigned FRAC = 1000;
  localparam int CLK_HALF = 10;

  localparam int THR_W      = ttdd_pkg::THR_W;
  localparam int DUTY_W     = ttdd_pkg::DUTY_W;
  localparam int CFG_DATA_W = ttdd_pkg::CFG_DATA_W;
  localparam int CFG_ADDR_W = ttdd_pkg::CFG_ADDR_W;
  localparam int REG_IDX_W  = ttdd_pkg::REG_IDX_W;

  typedef struct packed {
    logic              fwd;
    logic [DUTY_W-1:0] left;
    logic [DUTY_W-1:0] right;
  } drive_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic signed [SAMPLE_W-1:0]    in_tilt_x = '0;
  logic signed [SAMPLE_W-1:0]    in_tilt_y = '0;
  logic                          out_valid;
  logic                          out_drive_forward;
  logic [DUTY_W-1:0]             out_left_duty;
  logic [DUTY_W-1:0]             out_right_duty;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]         paddr = '0;
  logic [CFG_DATA_W-1:0]         pwdata = '0;
  logic [CFG_DATA_W-1:0]         prdata;
  logic                          pready;

  ttdd_pkg::cfg_regs_t cfg_now = '{ttdd_pkg::RST_FWD_DEAD, ttdd_pkg::RST_FWD_SAT,
                                   ttdd_pkg::RST_TURN_DEAD, ttdd_pkg::RST_TURN_SAT,
                                   ttdd_pkg::RST_FULL_SCALE};
  drive_t    pending_drive[$];
  drive_t    want;
  int        mismatch_count = 0;
  int        drive_checked = 0;
  int        sent_count = 0;
  int        settings_count = 1;
  bit        steady = 1'b0;

  tilt_to_differential_drive #(
    .SAMPLE_BITS    (SAMPLE_W),
    .FRACTION_SCALE (1000)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_tilt_x         (in_tilt_x),
    .in_tilt_y         (in_tilt_y),
    .out_valid         (out_valid),
    .out_drive_forward (out_drive_forward),
    .out_left_duty     (out_left_duty),
    .out_right_duty    (out_right_duty),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic longint shape_axis(logic signed [SAMPLE_W-1:0] v, logic [THR_W-1:0] dead,
                                        logic [THR_W-1:0] sat, logic [DUTY_W-1:0] fs);
    longint          sv;
    longint unsigned mag, d, s, f, span, r;
    sv = longint'(v);
    mag = (sv < 0) ? -sv : sv;
    d = 64'(dead);
    s = 64'(sat);
    f = 64'(fs);
    if (mag < d) return 0;
    if (mag > s) begin
      r = f;
    end else begin
      span = 0;
      if (f != 0) span = ((s - d) * FRAC) / f;
      if (span == 0) begin
        r = f;
      end else begin
        r = ((mag - d) * FRAC) / span;
        if (r > f) r = f;
      end
    end
    return (sv > 0) ? longint'(r) : -longint'(r);
  endfunction

  function automatic drive_t drive_for_tilt(logic signed [SAMPLE_W-1:0] x,
                                            logic signed [SAMPLE_W-1:0] y);
    longint          f, t;
    longint unsigned fs, base, left, right, tmag;
    drive_t          d;
    fs = 64'(cfg_now.full_scale);
    f = shape_axis(y, cfg_now.fwd_dead, cfg_now.fwd_sat, cfg_now.full_scale);
    t = shape_axis(x, cfg_now.turn_dead, cfg_now.turn_sat, cfg_now.full_scale);
    base = (f < 0) ? -f : f;
    tmag = (t < 0) ? -t : t;
    left = base;
    right = base;
    if (fs != 0) begin
      if (t > 0) right = right * (fs - tmag) / fs;
      else if (t < 0) left = left * (fs - tmag) / fs;
    end
    if (!(f > 0)) begin
      left = fs - left;
      right = fs - right;
    end
    d.fwd = (f > 0);
    d.left = left[DUTY_W-1:0];
    d.right = right[DUTY_W-1:0];
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
    case (idx)
      ttdd_pkg::REG_FWD_DEAD:   return CFG_DATA_W'(cfg_now.fwd_dead);
      ttdd_pkg::REG_FWD_SAT:    return CFG_DATA_W'(cfg_now.fwd_sat);
      ttdd_pkg::REG_TURN_DEAD:  return CFG_DATA_W'(cfg_now.turn_dead);
      ttdd_pkg::REG_TURN_SAT:   return CFG_DATA_W'(cfg_now.turn_sat);
      ttdd_pkg::REG_FULL_SCALE: return CFG_DATA_W'(cfg_now.full_scale);
      default:                  return '0;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_tilt(logic [THR_W-1:0] dead,
                                                           logic [THR_W-1:0] sat);
    int unsigned       lo, hi, mag;
    logic signed [16:0] val;
    case ($urandom_range(0, 7))
      0, 1: return SAMPLE_W'($urandom);
      6: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          3:       return 16'sh0001;
          default: return 16'shffff;
        endcase
      end
      default: begin
        lo = (dead > 200) ? dead - 200 : 0;
        hi = sat + 200;
        if (hi > 32768) hi = 32768;
        mag = $urandom_range(lo, hi);
        if (mag > 32768) mag = 32768;
        val = $urandom_range(0, 1) ? -17'(mag) : 17'(mag);
        return val[SAMPLE_W-1:0];
      end
    endcase
  endfunction

  task automatic check_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] rdata);
    if (rdata !== reg_value(idx)) begin
      $error("prdata[%0d]: expected %0d, got %0d", idx, reg_value(idx), rdata);
      mismatch_count++;
    end
  endtask

  task automatic apb_transfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) begin
      case (idx)
        ttdd_pkg::REG_FWD_DEAD:   cfg_now.fwd_dead = wdata[THR_W-1:0];
        ttdd_pkg::REG_FWD_SAT:    cfg_now.fwd_sat = wdata[THR_W-1:0];
        ttdd_pkg::REG_TURN_DEAD:  cfg_now.turn_dead = wdata[THR_W-1:0];
        ttdd_pkg::REG_TURN_SAT:   cfg_now.turn_sat = wdata[THR_W-1:0];
        ttdd_pkg::REG_FULL_SCALE: cfg_now.full_scale = wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  endtask

  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] readback;
    apb_transfer(1'b1, idx, value, readback);
    apb_transfer(1'b0, idx, '0, readback);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_reg(idx, readback);
  endtask

  task automatic set_all(input logic [THR_W-1:0] fd, input logic [THR_W-1:0] fsat,
                         input logic [THR_W-1:0] td, input logic [THR_W-1:0] tsat,
                         input logic [DUTY_W-1:0] fs);
    set_reg(ttdd_pkg::REG_FWD_DEAD, CFG_DATA_W'(fd));
    set_reg(ttdd_pkg::REG_FWD_SAT, CFG_DATA_W'(fsat));
    set_reg(ttdd_pkg::REG_TURN_DEAD, CFG_DATA_W'(td));
    set_reg(ttdd_pkg::REG_TURN_SAT, CFG_DATA_W'(tsat));
    set_reg(ttdd_pkg::REG_FULL_SCALE, CFG_DATA_W'(fs));
    settings_count++;
  endtask

  task automatic send_tilt(input logic signed [SAMPLE_W-1:0] x,
                           input logic signed [SAMPLE_W-1:0] y);
    start <= 1'b1;
    in_tilt_x <= x;
    in_tilt_y <= y;
    do @(posedge clk); while (busy);
    pending_drive.push_back(drive_for_tilt(x, y));
    sent_count++;
    if (!steady && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_values();
    logic [CFG_DATA_W-1:0] rdata;
    for (int i = 0; i <= ttdd_pkg::REG_FULL_SCALE; i++) begin
      apb_transfer(1'b0, REG_IDX_W'(i), '0, rdata);
      check_reg(REG_IDX_W'(i), rdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_extreme_tilts();
    send_tilt(16'sd0, 16'sd0);
    send_tilt(16'sh7fff, 16'sh7fff);
    send_tilt(16'sh8000, 16'sh8000);
    send_tilt(16'sh7fff, 16'sh8000);
    send_tilt(16'sh8000, 16'sh7fff);
    send_tilt(16'sd0, 16'sd2999);
    send_tilt(16'sd0, 16'sd3000);
    send_tilt(16'sd0, -16'sd3001);
    send_tilt(16'sd4000, 16'sd6000);
    send_tilt(-16'sd4000, 16'sd6001);
    send_tilt(16'sd5000, 16'sd4500);
    send_tilt(-16'sd5000, -16'sd4500);
    send_tilt(16'sd21845, -16'sd21846);
    send_tilt(-16'sd1, 16'sd1);
    drain_results();
  endtask

  task automatic test_zero_divisor();
    set_all(16'd1000, 16'd1002, 16'd1000, 16'd1000, 12'd4095);
    send_tilt(16'sd1000, 16'sd1001);
    send_tilt(-16'sd1000, -16'sd1002);
    send_tilt(16'sd999, 16'sd1000);
    drain_results();
  endtask

  task automatic test_zero_full_scale();
    set_all(16'd100, 16'd200, 16'd100, 16'd200, 12'd0);
    send_tilt(16'sd150, 16'sd150);
    send_tilt(16'sh8000, -16'sd150);
    drain_results();
  endtask

  task automatic test_inverted_thresholds();
    set_all(16'd8000, 16'd2000, 16'd9000, 16'd3000, 12'd1000);
    send_tilt(16'sd8999, 16'sd7999);
    send_tilt(-16'sd9000, 16'sd8000);
    drain_results();
  endtask

  task automatic test_register_extremes();
    set_all(16'd0, 16'd0, 16'd0, 16'd65535, 12'd1);
    send_tilt(16'sd1, 16'sd0);
    send_tilt(-16'sd20000, 16'sh7fff);
    drain_results();
    set_all(16'd65535, 16'd65535, 16'd0, 16'd32768, 12'd4095);
    send_tilt(16'sh8000, 16'sh8000);
    send_tilt(16'sd12345, 16'sh7fff);
    drain_results();
  endtask

  task automatic random_settings();
    logic [THR_W-1:0]  fd, fsat, td, tsat;
    logic [DUTY_W-1:0] fs;
    fd = THR_W'($urandom_range(0, 16000));
    fsat = ($urandom_range(0, 4) == 0) ? THR_W'($urandom)
                                       : THR_W'(fd + $urandom_range(0, 16000));
    td = THR_W'($urandom_range(0, 16000));
    tsat = ($urandom_range(0, 4) == 0) ? THR_W'($urandom)
                                       : THR_W'(td + $urandom_range(0, 16000));
    fs = ($urandom_range(0, 9) == 0) ? 12'd0 : DUTY_W'($urandom_range(1, 4095));
    set_all(fd, fsat, td, tsat, fs);
  endtask

  task automatic random_burst(input int count);
    for (int i = 0; i < count; i++)
      send_tilt(pick_tilt(cfg_now.turn_dead, cfg_now.turn_sat),
                pick_tilt(cfg_now.fwd_dead, cfg_now.fwd_sat));
    drain_results();
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 8; p++) begin
      random_settings();
      random_burst(150);
    end
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    random_settings();
    random_burst(200);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_drive.size() == 0) begin
        $error("result with no pending transaction");
        mismatch_count++;
      end else begin
        want = pending_drive.pop_front();
        drive_checked++;
        if (out_drive_forward !== want.fwd) begin
          $error("drive_forward: expected %0d, got %0d", want.fwd, out_drive_forward);
          mismatch_count++;
        end
        if (out_left_duty !== want.left) begin
          $error("left_duty: expected %0d, got %0d", want.left, out_left_duty);
          mismatch_count++;
        end
        if (out_right_duty !== want.right) begin
          $error("right_duty: expected %0d, got %0d", want.right, out_right_duty);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_extreme_tilts();
    test_zero_divisor();
    test_zero_full_scale();
    test_inverted_thresholds();
    test_register_extremes();
    test_random_settings();
    test_steady_stream();
    repeat (40) @(posedge clk);
    $display("Sent %0d tilt pairs across %0d register settings; checked %0d drive results.",
             sent_count, settings_count, drive_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * 400000);
    $error("run did not finish in time, %0d results still pending", pending_drive.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
